// ----- design/ssef_pkg.sv -----
// ssef_pkg: widths and reset constants shared by the standard error floor block
// no dependencies; imported by the core, the checker and the bench
package ssef_pkg;

	localparam int SAMPLE_W = 24;               // signed Q16.8 sample
	localparam int SUM_W    = 34;               // signed running sum, Q.8
	localparam int SQSUM_W  = 58;               // running sum of squares, Q.16
	localparam int MAXN_W   = 11;               // widest sample count
	localparam int N3_W     = 31;               // n cubed for n up to 1024
	localparam int M_W      = 67;               // n*sumsq - sum*sum
	localparam int FRAC_W   = 16;               // extra fraction bits for Q16.16
	localparam int DIVN_W   = M_W + FRAC_W;     // dividend width
	localparam int SQRT_W   = 64;               // root operand width
	localparam int RES_W    = 32;               // Q16.16 result
	localparam int DELTA_W  = 16;               // Q0.16 floor constant

	localparam logic [DELTA_W-1:0] DELTA_RESET = 16'd66;

endpackage

// ----- design/ssef_mul.sv -----
// ssef_mul: shift-add multiplier, one multiplier bit per cycle
// standalone; widths come from parameters
module ssef_mul #(
	parameter int AW = 58,
	parameter int BW = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             done,
	output logic [AW+BW-1:0] p
);

	localparam int PW = AW + BW;
	localparam int CW = $clog2(BW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] a_q;
	logic [PW-1:0] prod_q;
	logic [AW:0]   sum_w;

	// add the multiplicand into the upper half when the low bit is set
	assign sum_w = {1'b0, prod_q[PW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse once the last multiplier bit has been folded in
			done_q <= busy_q && !start && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{AW{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum_w, prod_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign p    = prod_q;

endmodule

// ----- design/ssef_div.sv -----
// ssef_div: restoring divider, one quotient bit per cycle
// standalone; widths come from parameters
module ssef_div #(
	parameter int NW = 83,
	parameter int DW = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial_w;
	logic [DW:0]   diff_w;
	logic          ge_w;

	// bring down the next dividend bit and try the subtract
	assign trial_w = {rem_q, quo_q[NW-1]};
	assign diff_w  = trial_w - {1'b0, den_q};
	assign ge_w    = trial_w >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse once the last quotient bit is in
			done_q <= busy_q && !start && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge_w ? diff_w[DW-1:0] : trial_w[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge_w};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- design/ssef_sqrt.sv -----
// ssef_sqrt: digit-by-digit integer square root, one root bit per cycle
// standalone; width comes from a parameter
module ssef_sqrt #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   x,
	output logic           done,
	output logic [W/2-1:0] root
);

	localparam int CW = $clog2(W/2 + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  res_q;
	logic [W-1:0]  bit_q;
	logic [W-1:0]  trial_w;

	assign trial_w = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse once the last root bit is settled
			done_q <= busy_q && !start && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W/2);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			res_q <= '0;
			bit_q <= {2'b01, {(W-2){1'b0}}};
		end else if (busy_q) begin
			if (x_q >= trial_w) begin
				x_q   <= x_q - trial_w;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[W/2-1:0];

endmodule

// ----- design/sample_standard_error_floor_core.sv -----
// sample_standard_error_floor_core: standard error of the mean with a delta floor
// a sample that is not last is folded into the run, and the next sample can be taken the cycle after
// a last sample stalls the input until its result has been loaded into the output register:
// five multiplier passes, two divider passes, two root passes
// arst_n clears the run accumulators and the result valid, the delta register returns to 66
// depends on ssef_pkg, ssef_mul, ssef_div and ssef_sqrt
module sample_standard_error_floor_core #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [ssef_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                 last_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ssef_pkg::RES_W-1:0]           sampling_error,
	output logic                                 floor_applied,
	output logic                                 capacity_overflow,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ssef_pkg::DELTA_W-1:0]         floor_delta
);
	import ssef_pkg::*;

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int MP_W  = SQSUM_W + SUM_W;

	// one step per shared unit pass; the result waits in S_OUT for a free output register
	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_MUL_A,
		S_MUL_B,
		S_MUL_N2,
		S_MUL_N3,
		S_DIV_M,
		S_SQRT_M,
		S_MUL_D,
		S_DIV_D,
		S_SQRT_D,
		S_OUT
	} state_t;

	state_t state_q;

	// run accumulators
	logic signed [SUM_W-1:0] sum_q;
	logic [SQSUM_W-1:0]      sumsq_q;
	logic [CNT_W-1:0]        count_q;
	logic                    ovf_q;
	logic [DELTA_W-1:0]      delta_q;

	// unit handshakes and operands
	logic                mul_start_q, div_start_q, sqrt_start_q;
	logic                mul_done, div_done, sqrt_done;
	logic [SQSUM_W-1:0]  mul_a_q;
	logic [SUM_W-1:0]    mul_b_q;
	logic [MP_W-1:0]     mul_p;
	logic [DIVN_W-1:0]   div_num_q;
	logic [N3_W-1:0]     div_den_q;
	logic [DIVN_W-1:0]   div_quo;
	logic [SQRT_W-1:0]   sqrt_x_q;
	logic [SQRT_W/2-1:0] sqrt_root;

	// intermediate results
	logic [M_W-1:0]     m_q;
	logic               sat_q;
	logic [RES_W-1:0]   comp_q;
	logic [DELTA_W-1:0] flo_q;

	// output register
	logic             out_valid_q;
	logic [RES_W-1:0] err_q;
	logic             applied_q;
	logic             cap_ovf_q;

	// combinational helpers
	logic                  in_go;
	logic                  out_load;
	logic                  full_w;
	logic [SAMPLE_W-1:0]   xm_w;
	logic [2*SAMPLE_W-1:0] sq_w;
	logic [SUM_W-1:0]      mag_w;
	logic [MAXN_W-1:0]     n_w;
	logic [RES_W-1:0]      flo_ext_w;

	assign in_go    = in_valid && !in_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign full_w   = count_q == CNT_W'(MAX_SAMPLES);

	// magnitude of the sample, then its square for the sum of squares
	assign xm_w = sample_value[SAMPLE_W-1] ? SAMPLE_W'(-sample_value) : sample_value;
	assign sq_w = (2*SAMPLE_W)'(xm_w) * (2*SAMPLE_W)'(xm_w);

	// magnitude of the running sum, squared by the shared multiplier
	assign mag_w     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign n_w       = MAXN_W'(count_q);
	assign flo_ext_w = RES_W'(flo_q);

	// control, accumulators, output register and the config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sum_q        <= '0;
			sumsq_q      <= '0;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			delta_q      <= DELTA_RESET;
			mul_start_q  <= 1'b0;
			div_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;
			out_valid_q  <= 1'b0;
			err_q        <= '0;
			applied_q    <= 1'b0;
			cap_ovf_q    <= 1'b0;
		end else begin
			// kick the next unit pass as the current one finishes
			mul_start_q  <= (state_q == S_START) ||
				(mul_done && (state_q == S_MUL_A || state_q == S_MUL_B ||
					state_q == S_MUL_N2)) ||
				(sqrt_done && state_q == S_SQRT_M);
			div_start_q  <= mul_done && (state_q == S_MUL_N3 || state_q == S_MUL_D);
			sqrt_start_q <= div_done && (state_q == S_DIV_M || state_q == S_DIV_D);
			// result held while stalled, replaced as soon as it leaves
			out_valid_q  <= out_load || (out_valid_q && out_stall);
			if (cfg_valid && cfg_ready) begin
				delta_q <= floor_delta;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_go) begin
						// a full run drops the sample but still honors its last mark
						if (full_w) begin
							ovf_q <= 1'b1;
						end else begin
							sum_q   <= sum_q + SUM_W'(sample_value);
							sumsq_q <= sumsq_q + SQSUM_W'(sq_w);
							count_q <= count_q + 1'b1;
						end
						if (last_sample) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					state_q <= S_MUL_A;
				end
				S_MUL_A: begin
					if (mul_done) begin
						state_q <= S_MUL_B;
					end
				end
				S_MUL_B: begin
					if (mul_done) begin
						state_q <= S_MUL_N2;
					end
				end
				S_MUL_N2: begin
					if (mul_done) begin
						state_q <= S_MUL_N3;
					end
				end
				S_MUL_N3: begin
					if (mul_done) begin
						state_q <= S_DIV_M;
					end
				end
				S_DIV_M: begin
					if (div_done) begin
						state_q <= S_SQRT_M;
					end
				end
				S_SQRT_M: begin
					if (sqrt_done) begin
						state_q <= S_MUL_D;
					end
				end
				S_MUL_D: begin
					if (mul_done) begin
						state_q <= S_DIV_D;
					end
				end
				S_DIV_D: begin
					if (div_done) begin
						state_q <= S_SQRT_D;
					end
				end
				S_SQRT_D: begin
					if (sqrt_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// publish the item and open the next run
					if (out_load) begin
						err_q     <= (comp_q < flo_ext_w) ? flo_ext_w : comp_q;
						applied_q <= comp_q < flo_ext_w;
						cap_ovf_q <= ovf_q;
						sum_q     <= '0;
						sumsq_q   <= '0;
						count_q   <= '0;
						ovf_q     <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operand staging and result capture, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_START: begin
				// a = n * sumsq
				mul_a_q <= sumsq_q;
				mul_b_q <= SUM_W'(n_w);
			end
			S_MUL_A: begin
				if (mul_done) begin
					m_q     <= mul_p[M_W-1:0];
					mul_a_q <= SQSUM_W'(mag_w);
					mul_b_q <= mag_w;
				end
			end
			S_MUL_B: begin
				if (mul_done) begin
					// deviation sum scaled by n, clamped at zero
					m_q     <= (m_q > mul_p[M_W-1:0]) ? m_q - mul_p[M_W-1:0] : '0;
					mul_a_q <= SQSUM_W'(n_w);
					mul_b_q <= SUM_W'(n_w);
				end
			end
			S_MUL_N2: begin
				if (mul_done) begin
					mul_a_q <= SQSUM_W'(mul_p[2*MAXN_W-1:0]);
					mul_b_q <= SUM_W'(n_w);
				end
			end
			S_MUL_N3: begin
				if (mul_done) begin
					// m * 2^16 / n^3 gives the squared Q16.16 error
					div_num_q <= {m_q, {FRAC_W{1'b0}}};
					div_den_q <= mul_p[N3_W-1:0];
				end
			end
			S_DIV_M: begin
				if (div_done) begin
					sat_q    <= |div_quo[DIVN_W-1:SQRT_W];
					sqrt_x_q <= div_quo[SQRT_W-1:0];
				end
			end
			S_SQRT_M: begin
				if (sqrt_done) begin
					comp_q  <= sat_q ? {RES_W{1'b1}} : sqrt_root;
					mul_a_q <= SQSUM_W'(delta_q);
					mul_b_q <= SUM_W'(delta_q);
				end
			end
			S_MUL_D: begin
				if (mul_done) begin
					// floor = sqrt(delta^2 / n)
					div_num_q <= DIVN_W'(mul_p[2*DELTA_W-1:0]);
					div_den_q <= N3_W'(n_w);
				end
			end
			S_DIV_D: begin
				if (div_done) begin
					sqrt_x_q <= div_quo[SQRT_W-1:0];
				end
			end
			S_SQRT_D: begin
				if (sqrt_done) begin
					flo_q <= sqrt_root[DELTA_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// shared iterative units
	ssef_mul #(
		.AW (SQSUM_W),
		.BW (SUM_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	ssef_div #(
		.NW (DIVN_W),
		.DW (N3_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	ssef_sqrt #(
		.W (SQRT_W)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start_q),
		.x      (sqrt_x_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// ports
	assign in_stall          = state_q != S_IDLE;
	assign cfg_ready         = state_q == S_IDLE;
	assign out_valid         = out_valid_q;
	assign sampling_error    = err_q;
	assign floor_applied     = applied_q;
	assign capacity_overflow = cap_ovf_q;

endmodule

// ----- design/ssef_chk.sv -----
// ssef_chk: port-level checks for sample_standard_error_floor_core
// depends on ssef_pkg; bound to sample_standard_error_floor_core at the end of this file
module ssef_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         last_sample,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [ssef_pkg::RES_W-1:0]   sampling_error,
	input logic                         floor_applied,
	input logic                         capacity_overflow,
	input logic                         cfg_ready
);
	import ssef_pkg::*;

	// a held result keeps its valid and payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sampling_error) &&
			$stable(floor_applied) && $stable(capacity_overflow))
		else $error("result item changed while stalled");

	// a sample that does not end the run leaves the block ready
	a_mid_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_sample |=> !in_stall)
		else $error("block stalled after a mid-run sample");

	// a last sample starts the end-of-run computation
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_sample |=> in_stall)
		else $error("block ready right after a last sample");

	// the floor is at most delta, which fits in the fraction
	a_floor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && floor_applied |-> sampling_error[RES_W-1:FRAC_W] == '0)
		else $error("floored result above delta");

	// config writes only land while the sample input is not stalled, between samples or runs
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !in_stall)
		else $error("config port open while computing");

endmodule

bind sample_standard_error_floor_core ssef_chk u_ssef_chk (.*);

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for sample_standard_error_floor_core, runs of Q16.8 samples in,
// one floored Q16.16 standard error out per run, checked against an in-bench fixed-point model
// depends on ssef_pkg and the sample_standard_error_floor_core RTL only
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ssef_pkg::*;

	localparam int CAPACITY    = 1024;    // samples held per run before the block drops
	localparam int HOLD_CYCLES = 2000;    // long receiver hold-off, fills the block
	localparam int SETTLE      = 8;
	localparam int TAIL_CYCLES = 500;
	localparam int STALL_LIMIT = 8000;    // cycles with no handshake before giving up
	localparam int PHASE_ITEMS = 180;     // random samples per idling phase

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

	// one result item as the block presents it
	typedef struct packed {
		logic [RES_W-1:0] err;
		logic             floored;
		logic             dropped;
	} sem_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_DELTA} row_kind_t;

	// value shapes for random runs
	typedef enum int {SPREAD_WIDE, SPREAD_TIGHT, SPREAD_EXTREME, SPREAD_FLAT} run_style_t;

	// directed row: either a delta write (block drained first) or one sample;
	// pinned rows carry a result read straight off the arithmetic
	typedef struct packed {
		row_kind_t                   kind;
		logic [DELTA_W-1:0]          delta;
		logic signed [SAMPLE_W-1:0]  value;
		logic                        last;
		logic                        pinned;
		sem_result_t                 want;
	} stim_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic signed [SAMPLE_W-1:0]  sample_value = '0;
	logic                        last_sample = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [RES_W-1:0]            sampling_error;
	logic                        floor_applied;
	logic                        capacity_overflow;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [DELTA_W-1:0]          floor_delta = DELTA_RESET;

	// model state, mirrors the run accumulators and the delta register
	logic signed [SUM_W-1:0]     acc_sum;
	logic [SQSUM_W-1:0]          acc_sqsum;
	logic [MAXN_W-1:0]           acc_count;
	logic                        acc_dropped;
	logic [DELTA_W-1:0]          delta_reg;

	sem_result_t                 pending_errors [$];

	// idling knobs, percent per cycle
	int unsigned tx_gap_pct = 0;
	int unsigned rx_stall_pct = 0;
	bit          hold_request = 1'b0;
	int          hold_left = 0;

	int error_count = 0;
	int mismatches = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int floored_seen = 0;
	int dropped_seen = 0;
	int delta_writes = 0;
	int quiet_cycles = 0;

	stim_row_t directed_rows [0:22] = '{
		// delta still at its reset value: lone sample, zero spread, floor of 66
		'{ROW_SAMPLE, 16'd0, 24'sd0, 1'b1, 1'b1, '{32'd66, 1'b1, 1'b0}},
		// full-scale pair, widest spread of two samples
		'{ROW_SAMPLE, 16'd0, SAMPLE_MAX, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, SAMPLE_MIN, 1'b1, 1'b0, '0},
		// zero delta: floor of zero never wins
		'{ROW_DELTA, 16'd0, 24'sd0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, 24'sd5, 1'b1, 1'b1, '{32'd0, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 16'd0, -24'sd1, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, 24'sd1, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, 24'sd256, 1'b1, 1'b0, '0},
		// largest delta
		'{ROW_DELTA, 16'd65535, 24'sd0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, SAMPLE_MIN, 1'b1, 1'b1, '{32'd65535, 1'b1, 1'b0}},
		// equal samples, deviation sum exactly zero, floor over three
		'{ROW_SAMPLE, 16'd0, 24'sd100, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, 24'sd100, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, 24'sd100, 1'b1, 1'b0, '0},
		'{ROW_DELTA, 16'd12345, 24'sd0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, SAMPLE_MAX, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, SAMPLE_MIN, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, SAMPLE_MAX, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, SAMPLE_MIN, 1'b1, 1'b0, '0},
		'{ROW_DELTA, 16'd66, 24'sd0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, 24'sd1, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, 24'sd0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, -24'sd1, 1'b1, 1'b0, '0},
		'{ROW_SAMPLE, 16'd0, SAMPLE_MAX, 1'b1, 1'b1, '{32'd66, 1'b1, 1'b0}}
	};

	sample_standard_error_floor_core #(
		.MAX_SAMPLES(CAPACITY)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample_value     (sample_value),
		.last_sample      (last_sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sampling_error   (sampling_error),
		.floor_applied    (floor_applied),
		.capacity_overflow(capacity_overflow),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.floor_delta      (floor_delta)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// integer square root, truncated, bit by bit from the top pair down
	function automatic logic [RES_W-1:0] int_root(input logic [SQRT_W-1:0] radicand);
		logic [SQRT_W-1:0] rest;
		logic [SQRT_W-1:0] root;
		logic [SQRT_W-1:0] probe;
		rest = radicand;
		root = '0;
		probe = 64'h4000_0000_0000_0000;
		while (probe > rest)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest = rest - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root[RES_W-1:0];
	endfunction

	// standard error of the current run with the delta floor applied
	function automatic sem_result_t run_std_error();
		sem_result_t       res;
		logic [SUM_W-1:0]  mag;
		logic [127:0]      n_sqsum;
		logic [127:0]      sum_sq;
		logic [127:0]      spread;
		logic [127:0]      scaled;
		logic [127:0]      n_cubed;
		logic [63:0]       delta_sq;
		logic [RES_W-1:0]  computed;
		logic [RES_W-1:0]  floor_val;
		mag = acc_sum[SUM_W-1] ? -acc_sum : acc_sum;
		n_sqsum = 128'(acc_count) * 128'(acc_sqsum);
		sum_sq = 128'(mag) * 128'(mag);
		// one-pass deviation sum n*sumsq - sum^2, never below zero
		spread = (n_sqsum > sum_sq) ? n_sqsum - sum_sq : '0;
		n_cubed = 128'(acc_count) * 128'(acc_count) * 128'(acc_count);
		scaled = (spread << FRAC_W) / n_cubed;
		computed = (scaled[127:64] != 0) ? '1 : int_root(scaled[63:0]);
		delta_sq = 64'(delta_reg) * 64'(delta_reg);
		floor_val = int_root(delta_sq / 64'(acc_count));
		res.dropped = acc_dropped;
		if (computed < floor_val) begin
			res.err = floor_val;
			res.floored = 1'b1;
		end else begin
			res.err = computed;
			res.floored = 1'b0;
		end
		return res;
	endfunction

	// fold one accepted sample into the run; on a last sample return the result and clear
	function automatic sem_result_t fold_sample(input logic signed [SAMPLE_W-1:0] v,
	                                            input logic is_last);
		logic [SAMPLE_W-1:0] mag;
		sem_result_t         res;
		res = '0;
		if (acc_count < CAPACITY) begin
			mag = v[SAMPLE_W-1] ? -v : v;
			acc_sum = acc_sum + v;
			acc_sqsum = acc_sqsum + 58'(mag) * 58'(mag);
			acc_count = acc_count + 1'b1;
		end else begin
			acc_dropped = 1'b1;
		end
		if (is_last) begin
			res = run_std_error();
			acc_sum = '0;
			acc_sqsum = '0;
			acc_count = '0;
			acc_dropped = 1'b0;
		end
		return res;
	endfunction

	// present one sample, called and returning at a falling edge, valid left high
	task automatic offer_sample(input logic signed [SAMPLE_W-1:0] v, input logic is_last,
	                            input logic pinned, input sem_result_t pinned_res);
		sem_result_t res;
		while ($urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= v;
		last_sample <= is_last;
		do
			@(posedge clk);
		while (in_stall);
		res = fold_sample(v, is_last);
		if (is_last)
			pending_errors = {pending_errors, pinned ? pinned_res : res};
		samples_sent++;
		@(negedge clk);
	endtask

	// drop valid and wait for every outstanding result, block then idle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_errors.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_delta(input logic [DELTA_W-1:0] value);
		cfg_valid <= 1'b1;
		floor_delta <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		delta_reg = value;
		delta_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly small deltas so the floor competes, extremes now and then
	function automatic logic [DELTA_W-1:0] pick_delta();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return 16'($urandom);
			3: return 16'($urandom_range(20));
			default: return 16'($urandom_range(1, 400));
		endcase
	endfunction

	// one well-formed run: random content, last flag on the final sample
	task automatic random_run(input int len);
		run_style_t                  style;
		logic signed [SAMPLE_W-1:0]  centre;
		logic signed [SAMPLE_W-1:0]  v;
		style = run_style_t'($urandom_range(3));
		centre = 24'($urandom);
		for (int k = 1; k <= len; k++) begin
			case (style)
				SPREAD_WIDE: v = 24'($urandom);
				SPREAD_TIGHT: v = centre + 24'($urandom_range(6)) - 24'sd3;
				SPREAD_EXTREME: begin
					case ($urandom_range(3))
						0: v = SAMPLE_MAX;
						1: v = SAMPLE_MIN;
						2: v = '0;
						default: v = $urandom_range(1) ? 24'sd1 : -24'sd1;
					endcase
				end
				default: v = centre;
			endcase
			offer_sample(v, k == len, 1'b0, '0);
		end
	endtask

	// mostly short runs, some medium, a few long
	function automatic int pick_run_len();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return $urandom_range(1, 8);
		else if (roll < 90)
			return $urandom_range(9, 40);
		return $urandom_range(41, 150);
	endfunction

	// random phase under given idling; optional mid-phase pause and receiver hold-off
	task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
	                            input bit mid_pause, input bit hold_off);
		int  start;
		bit  paused;
		drain();
		write_delta(pick_delta());
		tx_gap_pct = tx_pct;
		rx_stall_pct = rx_pct;
		if (hold_off)
			hold_request = 1'b1;
		start = samples_sent;
		paused = 1'b0;
		while (samples_sent - start < PHASE_ITEMS) begin
			random_run(pick_run_len());
			if (mid_pause && !paused && samples_sent - start >= PHASE_ITEMS / 2) begin
				// sender waits out every result, then a new delta
				drain();
				write_delta(pick_delta());
				paused = 1'b1;
			end
		end
	endtask

	// receiver: random stalls, or a long hold-off when one is asked for
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// result checker: each accepted result against the oldest expectation
	always @(posedge clk) begin
		sem_result_t got;
		sem_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{sampling_error, floor_applied, capacity_overflow};
			results_seen++;
			if (got.floored)
				floored_seen++;
			if (got.dropped)
				dropped_seen++;
			if (pending_errors.size() == 0) begin
				error_count++;
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: err %h floor %b ovf %b",
					         $realtime, got.err, got.floored, got.dropped);
			end else begin
				want = pending_errors.pop_front();
				if (got.err !== want.err || got.floored !== want.floored ||
				    got.dropped !== want.dropped) begin
					error_count++;
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch err exp %h got %h, floor exp %b got %b, ovf exp %b got %b",
						         $realtime, want.err, got.err, want.floored, got.floored,
						         want.dropped, got.dropped);
				end
			end
		end
	end

	// watchdog: any handshake on any channel resets the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d results outstanding",
			         STALL_LIMIT, pending_errors.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		acc_sum = '0;
		acc_sqsum = '0;
		acc_count = '0;
		acc_dropped = 1'b0;
		delta_reg = DELTA_RESET;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, sender gaps 35, receiver stalls 48
		tx_gap_pct = 35;
		rx_stall_pct = 48;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_DELTA) begin
				drain();
				write_delta(directed_rows[i].delta);
			end else begin
				offer_sample(directed_rows[i].value, directed_rows[i].last,
				             directed_rows[i].pinned, directed_rows[i].want);
			end
		end

		random_phase(35, 48, 1'b0, 1'b0);
		random_phase(48, 35, 1'b1, 1'b0);
		// no idling, but the receiver holds off at the start so the block backs up
		random_phase(0, 0, 1'b0, 1'b1);

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_errors.size() != 0)
			error_count++;
		$display("%0d samples in, %0d runs closed, %0d floored, %0d with dropped samples",
		         samples_sent, results_seen, floored_seen, dropped_seen);
		$display("%0d delta writes, %0d failures", delta_writes, error_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sample_standard_error_floor_core.f -----
design/ssef_pkg.sv
design/ssef_mul.sv
design/ssef_div.sv
design/ssef_sqrt.sv
design/sample_standard_error_floor_core.sv
design/ssef_chk.sv
tb/tb_top.sv
